// File: rtl/mpurac_pkg.sv
// Package for the protection-region access checker: sizes, input modes and the check token.
`timescale 1ns / 1ps

package mpurac_pkg;

    localparam int MAX_REGIONS = 8;
    localparam int ADDR_WIDTH  = 32;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

    // Field widths of one input item
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int FIELD_W = 32;
    localparam int PERM_W  = 8;
    localparam int COUNT_W = 8;

    // Input item kinds carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_CHECK = 2'd2
    } mode_t;

    // Access check token passed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] addr;
        logic [ADDR_WIDTH:0]   aend;
        logic [PERM_W-1:0]     need;
        logic                  hit;
    } chk_t;

endpackage

// File: rtl/mpurac_cell.sv
// One region slot of the checker chain: holds the region and tests the passing access.
`timescale 1ns / 1ps

module mpurac_cell
    import mpurac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_base,
    input  logic [ADDR_WIDTH-1:0] wr_size,
    input  logic [PERM_W-1:0]     wr_perms,
    input  logic                  active,
    input  chk_t                  chk_i,
    output chk_t                  chk_o
);

    logic [ADDR_WIDTH-1:0] base_reg;
    logic [ADDR_WIDTH:0]   end_reg;
    logic [PERM_W-1:0]     perms_reg;
    logic                  nz_reg;
    logic                  match;
    chk_t                  chk_reg;
    chk_t                  chk_next;

    // Store the region; keep its end one bit wider so it never wraps
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            base_reg  <= wr_base;
            end_reg   <= {1'b0, wr_base} + {1'b0, wr_size};
            perms_reg <= wr_perms;
        end
    end

    // Empty marker: cleared by reset, so unwritten slots never match
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg <= 1'b0;
        end else if (wr_en) begin
            nz_reg <= (wr_size != '0);
        end
    end

    // Test permissions and containment of the access in this region
    always_comb begin
        match = active && nz_reg
             && ((perms_reg & chk_i.need) == chk_i.need)
             && (chk_i.addr >= base_reg)
             && (chk_i.aend <= end_reg);
        chk_next     = chk_i;
        chk_next.hit = chk_i.hit | (chk_i.valid & match);
    end

    // Advance the token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_reg.valid <= 1'b0;
        end else begin
            chk_reg.valid <= chk_next.valid;
        end
        chk_reg.addr <= chk_next.addr;
        chk_reg.aend <= chk_next.aend;
        chk_reg.need <= chk_next.need;
        chk_reg.hit  <= chk_next.hit;
    end

    assign chk_o = chk_reg;

endmodule

// File: rtl/mpu_region_access_check.sv
// Top level of the protection-region access checker: stream ports, chain of region cells.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one transfer per item, kind in s_tuser (write slot, set active
//   count, check access), fields packed in s_tdata. Only a check produces a
//   result; it appears on the m_ channel as m_tdata[0] = permitted.
//   cfg_wr_en / cfg_wr_data set the enforcing bit; write it only while idle.
//   Slot writes and count writes are registered on their transfer. A check walks the chain
//   of MAX_REGIONS region cells, one cell per cycle, then passes a hold stage into the
//   output register; one check is in the chain at a time, and no further input is
//   taken while it is in flight.
//   The output register lets the next item be taken while a result waits.
//   If the receiver stalls, one finished check waits in a hold stage and all
//   further input is refused until the output register frees.
//   Reset (aresetn low, synchronous) empties all slots, clears the active count
//   and the enforcing bit, and drops any check in flight.
module mpu_region_access_check
    import mpurac_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: slot_index[3], region_base[32], region_size[32],
    // region_perms[8], region_count[8], access_addr[32], access_size[32],
    // access_perms[8], zero fill[5]
    input  logic [159:0] s_tdata,
    // s_tuser: mode[2]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: permitted[1], zero fill[7]
    output logic [7:0]   m_tdata
);

    // Input field unpacking
    logic [SLOT_W-1:0]     slot_index;
    logic [ADDR_WIDTH-1:0] region_base;
    logic [ADDR_WIDTH-1:0] region_size;
    logic [PERM_W-1:0]     region_perms;
    logic [COUNT_W-1:0]    region_count;
    logic [ADDR_WIDTH-1:0] access_addr;
    logic [ADDR_WIDTH-1:0] access_size;
    logic [PERM_W-1:0]     access_perms;

    assign slot_index   = s_tdata[2:0];
    assign region_base  = ADDR_WIDTH'(s_tdata[34:3]);
    assign region_size  = ADDR_WIDTH'(s_tdata[66:35]);
    assign region_perms = s_tdata[74:67];
    assign region_count = s_tdata[82:75];
    assign access_addr  = ADDR_WIDTH'(s_tdata[114:83]);
    assign access_size  = ADDR_WIDTH'(s_tdata[146:115]);
    assign access_perms = s_tdata[154:147];

    logic                 enforcing_reg;
    logic [CNT_W-1:0]     active_count_reg;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 zero_reg;
    logic                 pend_valid_reg;
    logic                 pend_hit_reg;
    logic                 m_tvalid_reg;
    logic                 permitted_reg;
    logic                 accept;
    logic                 is_check;
    logic                 out_load;
    logic [MAX_REGIONS-1:0] cell_wr;
    logic [MAX_REGIONS-1:0] cell_active;
    chk_t                 chain [MAX_REGIONS+1];

    assign accept   = s_tvalid & s_tready;
    assign is_check = (s_tuser == MODE_CHECK);
    assign s_tready = ~busy_reg;
    assign out_load = pend_valid_reg & (~m_tvalid_reg | m_tready);

    // Hold the enforcing bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enforcing_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enforcing_reg <= cfg_wr_data;
        end
    end

    // Set the active count; a count above the table depth gives zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= '0;
        end else if (accept && s_tuser == MODE_COUNT) begin
            if (region_count > COUNT_W'(MAX_REGIONS)) begin
                active_count_reg <= '0;
            end else begin
                active_count_reg <= CNT_W'(region_count);
            end
        end
    end

    // Busy from check transfer until its result enters the output register
    always_comb begin
        busy_next = busy_reg;
        if (accept && is_check) begin
            busy_next = 1'b1;
        end else if (out_load) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // Remember a zero-size access, refused while enforcing
    always_ff @(posedge aclk) begin
        if (accept && is_check) begin
            zero_reg <= (access_size == '0);
        end
    end

    // Feed the check token into the first cell
    always_comb begin
        chain[0].valid = accept & is_check;
        chain[0].addr  = access_addr;
        chain[0].aend  = {1'b0, access_addr} + {1'b0, access_size};
        chain[0].need  = access_perms;
        chain[0].hit   = 1'b0;
    end

    // Region cells, one per slot
    for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
        assign cell_wr[k]     = accept && (s_tuser == MODE_WRITE)
                             && (7'(slot_index) == 7'(k));
        assign cell_active[k] = (active_count_reg > CNT_W'(k));

        mpurac_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (cell_wr[k]),
            .wr_base  (region_base),
            .wr_size  (region_size),
            .wr_perms (region_perms),
            .active   (cell_active[k]),
            .chk_i    (chain[k]),
            .chk_o    (chain[k+1])
        );
    end

    // Hold a finished check until the output register is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (chain[MAX_REGIONS].valid) begin
            pend_valid_reg <= 1'b1;
        end else if (out_load) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (chain[MAX_REGIONS].valid) begin
            pend_hit_reg <= chain[MAX_REGIONS].hit;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            permitted_reg <= ~enforcing_reg | (~zero_reg & pend_hit_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, permitted_reg};

endmodule
